// ===== sv/bni_pkg.sv =====
// Shared types and constants for the batch normalization inference core.
package bni_pkg;

	localparam int unsigned EPS_W   = 24;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned CH_W    = 8;
	localparam int unsigned Q_W     = 16;
	localparam int unsigned GAIN_W  = 32;
	localparam int unsigned VSUM_W  = 25;

	localparam logic [EPS_W-1:0]   EPS_RESET   = 24'd1;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_SATURATED = 2'd1,
		ST_RANGE     = 2'd2
	} status_t;

	typedef enum logic {
		REG_EPSILON = 1'b0,
		REG_COUNT   = 1'b1
	} reg_idx_t;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef struct packed {
		logic                    start;
		logic signed [Q_W-1:0]   scale;
		logic [VSUM_W-1:0]       var_sum;
	} gain_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [GAIN_W-1:0] gain;
	} gain_rsp_t;

endpackage

// ===== sv/batch_norm_inference_core.sv =====
// Top level of the batch normalization inference core.
//  channel   | direction | payload
//  s_axis    | in        | tuser op; tdata channel, sample, scale, bias, mean, variance
//  m_axis    | out       | tdata result, status
//  apb       | in/out    | reg 0 epsilon (0x0), reg 1 channel_count (0x4)
// Samples: one request a cycle while no load is pending and the result is not stalled;
// result passes through the read, multiply and round stages. Loads: serial divider and
// square root, skipped for a zero variance sum; requests held meanwhile.
// Reset clears control state, sets epsilon 1 and channel_count 256; parameter memories
// hold nothing until loaded. A stalled result holds the whole sample pipeline.
module batch_norm_inference_core #(
	parameter int unsigned CHANNELS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] channel, [23:8] sample, [39:24] scale, [55:40] bias, [71:56] mean,
	// [95:72] variance
	input  logic [95:0] s_axis_tdata,
	// [0] op
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] result, [17:16] status, [23:18] zero
	output logic [23:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bni_pkg::*;

	localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [EPS_W-1:0]   eps_q;
	logic [COUNT_W-1:0] count_q;
	logic               busy_q;
	logic [AW-1:0]      pend_addr_q;
	logic signed [15:0] pend_mean_q, pend_bias_q;

	logic [CH_W-1:0]    ch;
	logic signed [15:0] sample, scale, bias, mean;
	logic [23:0]        variance;
	logic               in_fire, in_range, load_go, advance;
	gain_req_t          greq;
	gain_rsp_t          grsp;
	logic signed [15:0] result;
	status_t            status;
	logic               wr_cfg;

	assign ch       = s_axis_tdata[7:0];
	assign sample   = s_axis_tdata[23:8];
	assign scale    = s_axis_tdata[39:24];
	assign bias     = s_axis_tdata[55:40];
	assign mean     = s_axis_tdata[71:56];
	assign variance = s_axis_tdata[95:72];

	assign in_range = (32'(ch) < 32'(count_q)) && (32'(ch) < CHANNELS);
	assign s_axis_tready = advance && !busy_q;
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign load_go  = in_fire && (s_axis_tuser == OP_LOAD) && in_range;

	assign greq.start   = load_go;
	assign greq.scale   = scale;
	assign greq.var_sum = 25'(variance) + 25'(eps_q);

	assign pready = 1'b1;
	assign wr_cfg = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_EPSILON: prdata = 32'(eps_q);
			REG_COUNT:   prdata = 32'(count_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q   <= EPS_RESET;
			count_q <= COUNT_RESET;
			busy_q  <= 1'b0;
		end else begin
			if (wr_cfg) begin
				case (reg_idx_t'(paddr[2]))
					REG_EPSILON: eps_q   <= pwdata[EPS_W-1:0];
					REG_COUNT:   count_q <= pwdata[COUNT_W-1:0];
					default:     eps_q   <= eps_q;
				endcase
			end
			if (load_go) begin
				busy_q <= 1'b1;
			end else if (grsp.done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_go) begin
			pend_addr_q <= AW'(ch);
			pend_mean_q <= mean;
			pend_bias_q <= bias;
		end
	end

	bni_gain_unit u_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (greq),
		.rsp    (grsp)
	);

	bni_sample_path #(
		.AW (AW)
	) u_path (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (in_fire && (s_axis_tuser == OP_SAMPLE)),
		.range_err (!in_range),
		.rd_addr   (AW'(ch)),
		.sample    (sample),
		.wr_en     (grsp.done),
		.wr_addr   (pend_addr_q),
		.wr_gain   (grsp.gain),
		.wr_mean   (pend_mean_q),
		.wr_bias   (pend_bias_q),
		.advance   (advance),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.result    (result),
		.status    (status)
	);

	assign m_axis_tdata = {6'd0, status, result};

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !s_axis_tready)
		else $error("request accepted during parameter load");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		grsp.done |-> busy_q)
		else $error("gain finished with no load pending");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load_go |=> busy_q)
		else $error("load did not start gain unit");

endmodule

// ===== sv/bni_gain_unit.sv =====
// Gain unit: scale / sqrt(variance + epsilon) by serial division and square root.
module bni_gain_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  bni_pkg::gain_req_t req,
	output bni_pkg::gain_rsp_t rsp
);
	import bni_pkg::*;

	typedef enum logic [4:0] {
		G_IDLE = 5'b00001,
		G_SQR  = 5'b00010,
		G_DIV  = 5'b00100,
		G_SQRT = 5'b01000,
		G_FIN  = 5'b10000
	} gstate_t;

	gstate_t              state_q;
	logic                 neg_q;
	logic [15:0]          mag_q;
	logic [VSUM_W-1:0]    s_q;
	logic [63:0]          num_q;
	logic [35:0]          rem_q;
	logic [32:0]          root_q;
	logic [5:0]           cnt_q;
	logic                 done_q;
	logic signed [31:0]   gain_q;

	logic [15:0] mag_c;
	logic [25:0] div_sh;
	logic        div_ge;
	logic [35:0] sq_sh;
	logic [35:0] sq_trial;
	logic        sq_ge;
	logic [32:0] k_c;
	logic [31:0] gain_c;

	always_comb begin
		mag_c    = req.scale[15] ? 16'(-req.scale) : 16'(req.scale);
		div_sh   = {rem_q[24:0], num_q[63]};
		div_ge   = div_sh >= {1'b0, s_q};
		sq_sh    = {rem_q[33:0], num_q[63:62]};
		sq_trial = {1'b0, root_q, 2'b01};
		sq_ge    = sq_sh >= sq_trial;
		k_c      = (s_q == '0) ? 33'h0_8000_0000 : root_q;
		if (mag_q == '0) begin
			gain_c = '0;
		end else if (!neg_q) begin
			gain_c = (k_c > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : k_c[31:0];
		end else begin
			gain_c = (k_c >= 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-k_c[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				G_IDLE: begin
					if (req.start) begin
						state_q <= G_SQR;
					end
				end
				G_SQR: begin
					cnt_q   <= '0;
					state_q <= (s_q == '0) ? G_FIN : G_DIV;
				end
				G_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						cnt_q   <= '0;
						state_q <= G_SQRT;
					end
				end
				G_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						state_q <= G_FIN;
					end
				end
				G_FIN: begin
					done_q  <= 1'b1;
					state_q <= G_IDLE;
				end
				default: begin
					state_q <= G_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			G_IDLE: begin
				if (req.start) begin
					mag_q <= mag_c;
					neg_q <= req.scale[15];
					s_q   <= req.var_sum;
				end
			end
			G_SQR: begin
				num_q  <= {32'(mag_q * mag_q), 32'd0};
				rem_q  <= '0;
				root_q <= '0;
			end
			G_DIV: begin
				rem_q <= div_ge ? 36'(div_sh - {1'b0, s_q}) : 36'(div_sh);
				num_q <= {num_q[62:0], div_ge};
				if (cnt_q == 6'd63) begin
					rem_q <= '0;
				end
			end
			G_SQRT: begin
				rem_q  <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
				root_q <= {root_q[31:0], sq_ge};
				num_q  <= {num_q[61:0], 2'b00};
			end
			G_FIN: begin
				gain_q <= gain_c;
			end
			default: begin
				gain_q <= gain_q;
			end
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.gain = gain_q;

endmodule

// ===== sv/bni_sample_path.sv =====
// Channel parameter memories and the sample normalize pipeline.
module bni_sample_path #(
	parameter int unsigned AW = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic                 range_err,
	input  logic [AW-1:0]        rd_addr,
	input  logic signed [15:0]   sample,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic signed [31:0]   wr_gain,
	input  logic signed [15:0]   wr_mean,
	input  logic signed [15:0]   wr_bias,
	output logic                 advance,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [15:0]   result,
	output bni_pkg::status_t     status
);
	import bni_pkg::*;

	localparam int unsigned DEPTH = 1 << AW;

	logic signed [31:0] gain_mem [DEPTH];
	logic signed [15:0] mean_mem [DEPTH];
	logic signed [15:0] bias_mem [DEPTH];

	logic               valid_s1, valid_s2, out_valid_q;
	logic               err_s1, err_s2;
	logic signed [15:0] sample_s1;
	logic signed [31:0] gain_s1;
	logic signed [15:0] mean_s1, bias_s1, bias_s2;
	logic signed [48:0] prod_s2;
	logic signed [15:0] result_q;
	status_t            status_q;

	logic signed [16:0] diff_c;
	logic signed [50:0] acc_c;
	logic signed [34:0] res_c;

	assign advance = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			gain_mem[wr_addr] <= wr_gain;
			mean_mem[wr_addr] <= wr_mean;
			bias_mem[wr_addr] <= wr_bias;
		end
		if (advance) begin
			gain_s1 <= gain_mem[rd_addr];
			mean_s1 <= mean_mem[rd_addr];
			bias_s1 <= bias_mem[rd_addr];
		end
	end

	always_comb begin
		diff_c = 17'(sample_s1) - 17'(mean_s1);
		acc_c  = 51'(prod_s2) + {35'(bias_s2), 16'd0} + 51'sd32768;
		res_c  = 35'(acc_c >>> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= fire;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_s1 <= sample;
			err_s1    <= range_err;
			prod_s2   <= 49'(diff_c) * 49'(gain_s1);
			bias_s2   <= bias_s1;
			err_s2    <= err_s1;
			if (err_s2) begin
				result_q <= '0;
				status_q <= ST_RANGE;
			end else if (res_c > 35'sd32767) begin
				result_q <= 16'sh7FFF;
				status_q <= ST_SATURATED;
			end else if (res_c < -35'sd32768) begin
				result_q <= 16'sh8000;
				status_q <= ST_SATURATED;
			end else begin
				result_q <= res_c[15:0];
				status_q <= ST_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign status    = status_q;

endmodule

// ===== sim/batch_norm_inference_core_tb.sv =====
// Self-checking testbench for the batch normalization inference core.
`timescale 1ns / 1ps

module batch_norm_inference_core_tb;
	import bni_pkg::*;

	typedef struct {
		op_t                   op;
		logic [CH_W-1:0]       ch;
		logic signed [Q_W-1:0] smp;
		logic signed [Q_W-1:0] scl;
		logic signed [Q_W-1:0] bia;
		logic signed [Q_W-1:0] mn;
		logic [EPS_W-1:0]      vr;
	} bn_req_t;

	typedef struct {
		logic signed [Q_W-1:0] value;
		status_t               status;
	} norm_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;  // [7:0] channel, [23:8] sample, [39:24] scale,
	                                 // [55:40] bias, [71:56] mean, [95:72] variance
	logic        s_axis_tuser = 1'b0; // [0] op
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;       // [15:0] result, [17:16] status, [23:18] zero
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	batch_norm_inference_core u_dut (.*);

	bn_req_t   pending_reqs[$];
	norm_out_t expected_norms[$];

	logic [EPS_W-1:0]          eps_reg = EPS_RESET;
	logic [COUNT_W-1:0]        count_reg = COUNT_RESET;
	logic signed [GAIN_W-1:0]  gain_tbl[256];
	logic signed [Q_W-1:0]     mean_tbl[256];
	logic signed [Q_W-1:0]     bias_tbl[256];
	bit                        filled[256];
	int unsigned               gen_count = 256;
	bit                        quiet = 1'b0;
	int unsigned               in_gap = 0;
	int unsigned               out_gap = 0;
	int unsigned               n_loads = 0, n_samples = 0, n_results = 0, n_errors = 0;
	int unsigned               n_sat = 0, n_range = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic signed [GAIN_W-1:0] gain_of(logic signed [Q_W-1:0] sc,
	                                                      logic [EPS_W-1:0] v);
		longint unsigned s, mag, q, lo, hi, mid, k;
		longint sl;
		sl = sc;
		s = longint'(v) + longint'(eps_reg);
		mag = sl < 0 ? -sl : sl;
		if (mag == 0)
			return '0;
		if (s == 0) begin
			k = 64'd1 << 31;
		end else begin
			q = ((mag << 16) * (mag << 16)) / s;
			lo = 0;
			hi = 64'd1 << 32;
			while (hi - lo > 1) begin
				mid = lo + (hi - lo) / 2;
				if (mid * mid <= q)
					lo = mid;
				else
					hi = mid;
			end
			k = lo;
		end
		if (sl > 0)
			return (k > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : GAIN_W'(k);
		if (k > (64'd1 << 31))
			k = 64'd1 << 31;
		return GAIN_W'(-longint'(k));
	endfunction

	function automatic norm_out_t normalise(bn_req_t r);
		norm_out_t o;
		longint acc;
		acc = (longint'(r.smp) - longint'(mean_tbl[r.ch])) * longint'(gain_tbl[r.ch])
		      + longint'(bias_tbl[r.ch]) * 65536;
		acc = (acc + 32768) >>> 16;
		o.status = ST_OK;
		if (acc > 32767) begin
			acc = 32767;
			o.status = ST_SATURATED;
		end else if (acc < -32768) begin
			acc = -32768;
			o.status = ST_SATURATED;
		end
		o.value = Q_W'(acc);
		return o;
	endfunction

	function automatic int unsigned in_use();
		return (count_reg < 256) ? count_reg : 256;
	endfunction

	// input driver
	always @(posedge clk) begin
		if (arst_n && (!s_axis_tvalid || s_axis_tready)) begin
			if (in_gap > 0 && !quiet) begin
				s_axis_tvalid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending_reqs.size() > 0) begin
				bn_req_t r;
				r = pending_reqs.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= r.op;
				s_axis_tdata <= {r.vr, r.mn, r.bia, r.scl, r.smp, r.ch};
				if (!quiet && $urandom_range(0, 9) == 0)
					in_gap <= $urandom_range(1, 18);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// prediction on accepted requests
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			bn_req_t r;
			norm_out_t o;
			r.op = op_t'(s_axis_tuser);
			{r.vr, r.mn, r.bia, r.scl, r.smp, r.ch} = s_axis_tdata;
			if (r.op == OP_LOAD) begin
				n_loads++;
				if (r.ch < in_use()) begin
					gain_tbl[r.ch] = gain_of(r.scl, r.vr);
					bias_tbl[r.ch] = r.bia;
					mean_tbl[r.ch] = r.mn;
				end
			end else begin
				n_samples++;
				if (r.ch < in_use()) begin
					o = normalise(r);
				end else begin
					o.value = '0;
					o.status = ST_RANGE;
				end
				expected_norms.push_back(o);
			end
		end
	end

	// result monitor and back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (quiet) begin
				m_axis_tready <= 1'b1;
			end else if (out_gap > 0) begin
				m_axis_tready <= 1'b0;
				out_gap <= out_gap - 1;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 9) == 0)
					out_gap <= $urandom_range(1, 18);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				norm_out_t e;
				n_results++;
				if (expected_norms.size() == 0) begin
					$display("%0t: result expected none actual %h", $time, m_axis_tdata);
					n_errors++;
				end else begin
					e = expected_norms.pop_front();
					if (e.status == ST_SATURATED) n_sat++;
					if (e.status == ST_RANGE) n_range++;
					if (m_axis_tdata[15:0] !== e.value) begin
						$display("%0t: result expected %h actual %h", $time, e.value,
						         m_axis_tdata[15:0]);
						n_errors++;
					end
					if (m_axis_tdata[17:16] !== e.status) begin
						$display("%0t: status expected %0d actual %0d", $time, e.status,
						         m_axis_tdata[17:16]);
						n_errors++;
					end
					if (m_axis_tdata[23:18] !== 6'd0) begin
						$display("%0t: pad expected 0 actual %h", $time, m_axis_tdata[23:18]);
						n_errors++;
					end
				end
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_EPSILON)
			eps_reg = val[EPS_W-1:0];
		else
			count_reg = val[COUNT_W-1:0];
		gen_count = (count_reg < 256) ? count_reg : 256;
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || expected_norms.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic logic [15:0] rnd16();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 1023)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [23:0] rnd24();
		case ($urandom_range(0, 5))
			0: return 24'h0;
			1: return 24'hFFFFFF;
			2: return 24'($urandom_range(1, 300));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic void push_req(op_t op, logic [7:0] ch, logic [15:0] smp,
	                                 logic [15:0] scl, logic [15:0] bia, logic [15:0] mn,
	                                 logic [23:0] vr);
		bn_req_t r;
		r = '{op, ch, smp, scl, bia, mn, vr};
		if (op == OP_LOAD && ch < gen_count)
			filled[ch] = 1'b1;
		pending_reqs.push_back(r);
	endfunction

	function automatic void random_phase(int unsigned n);
		int unsigned ch, sel, tries;
		repeat (n) begin
			sel = $urandom_range(0, 99);
			ch = $urandom_range(0, gen_count - 1);
			tries = 0;
			while (!filled[ch] && tries < 20) begin
				ch = $urandom_range(0, gen_count - 1);
				tries++;
			end
			if (sel < 10 && gen_count < 256) begin
				ch = $urandom_range(gen_count, 255);
				push_req(op_t'(sel[0]), 8'(ch), rnd16(), rnd16(), rnd16(), rnd16(), rnd24());
			end else if (sel < 35 || !filled[ch]) begin
				if (sel < 15)
					ch = $urandom_range(0, gen_count - 1);
				push_req(OP_LOAD, 8'(ch), rnd16(), rnd16(), rnd16(), rnd16(), rnd24());
			end else begin
				push_req(OP_SAMPLE, 8'(ch), rnd16(), rnd16(), rnd16(), rnd16(), rnd24());
			end
		end
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_req(OP_LOAD, 0, 16'h1234, 16'h7FFF, 16'h0100, 16'h0000, 24'h000000);
		push_req(OP_LOAD, 1, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 24'hFFFFFF);
		push_req(OP_LOAD, 2, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 24'h010000);
		push_req(OP_LOAD, 255, 16'h0000, 16'h0100, 16'h0000, 16'h0080, 24'h00FFFF);
		push_req(OP_SAMPLE, 0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
		push_req(OP_SAMPLE, 0, 16'h0001, 16'h0, 16'h0, 16'h0, 24'h0);
		push_req(OP_SAMPLE, 1, 16'h8000, 16'h0, 16'h0, 16'h0, 24'h0);
		push_req(OP_SAMPLE, 1, 16'h7FFF, 16'h0, 16'h0, 16'h0, 24'h0);
		push_req(OP_SAMPLE, 2, 16'h7FFF, 16'h0, 16'h0, 16'h0, 24'h0);
		push_req(OP_SAMPLE, 255, 16'h8000, 16'h0, 16'h0, 16'h0, 24'h0);
		push_req(OP_SAMPLE, 255, 16'h0180, 16'h0, 16'h0, 16'h0, 24'h0);
		drain();

		reg_write(REG_EPSILON, 32'h0);
		push_req(OP_LOAD, 3, 16'h0, 16'h0001, 16'h0, 16'h0, 24'h0);
		push_req(OP_LOAD, 4, 16'h0, 16'hFFFF, 16'h0, 16'h0, 24'h0);
		push_req(OP_LOAD, 5, 16'h0, 16'h0000, 16'h0, 16'h0, 24'h0);
		push_req(OP_SAMPLE, 3, 16'h0001, 16'h0, 16'h0, 16'h0, 24'h0);
		push_req(OP_SAMPLE, 4, 16'h0001, 16'h0, 16'h0, 16'h0, 24'h0);
		push_req(OP_SAMPLE, 5, 16'h7FFF, 16'h0, 16'h0, 16'h0, 24'h0);
		drain();

		reg_write(REG_COUNT, 32'd1);
		push_req(OP_LOAD, 200, 16'h0, 16'h0100, 16'h0, 16'h0, 24'h100);
		push_req(OP_SAMPLE, 200, 16'h0100, 16'h0, 16'h0, 16'h0, 24'h0);
		push_req(OP_SAMPLE, 0, 16'h0100, 16'h0, 16'h0, 16'h0, 24'h0);
		drain();

		reg_write(REG_EPSILON, 32'hFFFFFF);
		reg_write(REG_COUNT, 32'd17);
		random_phase(80);
		drain();
		reg_write(REG_EPSILON, $urandom_range(1, 4096));
		reg_write(REG_COUNT, 32'd511);
		random_phase(90);
		drain();
		reg_write(REG_EPSILON, $urandom);
		reg_write(REG_COUNT, $urandom_range(2, 255));
		random_phase(90);
		drain();
		reg_write(REG_EPSILON, 32'd1);
		reg_write(REG_COUNT, 32'd256);
		random_phase(100);
		drain();
		quiet = 1'b1;
		random_phase(90);
		drain();

		$display("covered %0d loads and %0d samples, %0d results checked",
		         n_loads, n_samples, n_results);
		$display("saturated results %0d, out-of-range channels %0d", n_sat, n_range);
		if (n_errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#8ms;
		$display("timeout waiting for results");
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
